FILE: hdl/d2i_pkg.sv
// Shared types and constants for the binary64 to int64 conversion core.
// No dependencies.
package d2i_pkg;

    typedef enum logic [1:0] {
        RM_NEAREST  = 2'd0,
        RM_FLOOR    = 2'd1,
        RM_CEIL     = 2'd2,
        RM_TRUNC    = 2'd3
    } t_rmode;

    localparam logic [63:0] INT64_MAX_BITS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] INT64_MIN_BITS = 64'h8000_0000_0000_0000;
    localparam logic [10:0] EXP_ALL_ONES   = 11'h7FF;
    localparam logic [10:0] EXP_SATURATE   = 11'd1086;
    localparam logic [10:0] EXP_BIAS_SHIFT = 11'd1075;

    // Stage 1 to stage 2 control
    typedef struct packed {
        logic        special;   // result fully decided in stage 1
        logic [63:0] special_val;
        logic        neg;
        logic        left;      // integer shift left
        logic [6:0]  shamt;     // shift amount (left <= 10, right <= 54)
        logic [52:0] sig;
        t_rmode      rmode;
    } t_dec;

endpackage

FILE: hdl/d2i_round.sv
// Stage 3 of the core: rounding increment and sign application.
// Depends on d2i_pkg.
module d2i_round import d2i_pkg::*; (
    input  logic        i_neg,
    input  logic [62:0] i_ipart,
    input  logic        i_rbit,
    input  logic        i_frac,
    input  t_rmode      i_rmode,
    output logic [63:0] o_value
);
    logic        inc;
    logic [63:0] mag;

    // pick increment by mode
    always_comb begin
        unique case (i_rmode)
            RM_NEAREST: inc = i_rbit;
            RM_FLOOR:   inc = i_neg & i_frac;
            RM_CEIL:    inc = ~i_neg & i_frac;
            RM_TRUNC:   inc = 1'b0;
            default:    inc = 1'b0;
        endcase
        mag     = {1'b0, i_ipart} + {63'd0, inc};
        o_value = i_neg ? (64'd0 - mag) : mag;
    end
endmodule

FILE: hdl/double_to_int64_rounding_core.sv
// Top level of the binary64 to int64 conversion core; three register stages.
// Depends on d2i_pkg and d2i_round.
//
//  channel | ports                              | beat marker
//  --------+------------------------------------+---------------------
//  input   | i_value_bits[63:0], i_mode[1:0]    | start && !busy
//  result  | o_result[63:0]                     | o_strobe
//
// One beat enters every cycle. Stage 1 decodes the fields, stage 2 runs the
// barrel shift and sticky collection, stage 3 rounds and negates. busy stays
// low: the receiver cannot stall and nothing waits.
// Synchronous active-low reset clears the valid bits only.
module double_to_int64_rounding_core import d2i_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] i_value_bits,
    input  logic [1:0]  i_mode,
    output logic        o_strobe,
    output logic [63:0] o_result
);
    logic        r_v1, r_v2, r_v3;
    t_dec        r_dec, n_dec;
    logic        r_sp2, r_neg2, r_rbit2, r_frac2;
    logic [63:0] r_spv2;
    logic [62:0] r_ip2;
    t_rmode      r_rm2;
    logic [63:0] r_res, n_res;
    logic [62:0] n_ip;
    logic        n_rbit, n_frac;
    logic [10:0] ex, exe;
    logic [51:0] fr;
    logic [10:0] rsh;
    logic [52:0] mask;
    logic [53:0] sigx;
    logic [63:0] rnd_val;

    assign busy = 1'b0;

    // stage 1: decode fields
    always_comb begin
        ex  = i_value_bits[62:52];
        fr  = i_value_bits[51:0];
        exe = (ex == 11'd0) ? 11'd1 : ex;
        rsh = EXP_BIAS_SHIFT - exe;
        n_dec.neg   = i_value_bits[63];
        n_dec.sig   = {(ex != 11'd0), fr};
        n_dec.rmode = t_rmode'(i_mode);
        n_dec.left  = (exe >= EXP_BIAS_SHIFT);
        n_dec.shamt = n_dec.left ? 7'(exe - EXP_BIAS_SHIFT)
                                 : ((rsh >= 11'd54) ? 7'd54 : rsh[6:0]);
        n_dec.special     = 1'b0;
        n_dec.special_val = 64'd0;
        if (ex == EXP_ALL_ONES && fr != 52'd0) begin
            n_dec.special = 1'b1;
        end else if (ex >= EXP_SATURATE) begin
            n_dec.special     = 1'b1;
            n_dec.special_val = i_value_bits[63] ? INT64_MIN_BITS : INT64_MAX_BITS;
        end
    end

    // stage 2: shift, round bit and sticky
    always_comb begin
        mask = 53'd0;
        sigx = {r_dec.sig, 1'b0};
        if (r_dec.left) begin
            n_ip   = 63'({10'd0, r_dec.sig} << r_dec.shamt[3:0]);
            n_rbit = 1'b0;
            n_frac = 1'b0;
        end else begin
            n_ip   = 63'({10'd0, r_dec.sig} >> r_dec.shamt);
            // drop the round bit once the whole significand is below half
            n_rbit = (r_dec.shamt == 7'd0 || r_dec.shamt >= 7'd54) ? 1'b0
                                                                  : sigx[r_dec.shamt[5:0]];
            mask   = ~(53'h1F_FFFF_FFFF_FFFF << r_dec.shamt);
            n_frac = |(r_dec.sig & mask);
        end
    end

    d2i_round u_round (
        .i_neg   (r_neg2),
        .i_ipart (r_ip2),
        .i_rbit  (r_rbit2),
        .i_frac  (r_frac2),
        .i_rmode (r_rm2),
        .o_value (rnd_val)
    );

    assign n_res = r_sp2 ? r_spv2 : rnd_val;

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // advance payload
    always_ff @(posedge i_clk) begin
        r_dec   <= n_dec;
        r_sp2   <= r_dec.special;
        r_spv2  <= r_dec.special_val;
        r_neg2  <= r_dec.neg;
        r_ip2   <= n_ip;
        r_rbit2 <= n_rbit;
        r_frac2 <= n_frac;
        r_rm2   <= r_dec.rmode;
        r_res   <= n_res;
    end

    assign o_strobe = r_v3;
    assign o_result = r_res;
endmodule

FILE: verif/tb_top.sv
// Testbench for the binary64 to int64 rounding core: random and directed values,
// checked against a bit-level predictor in the order the results come back.
// Depends on d2i_pkg and double_to_int64_rounding_core.
module tb_top;
    import d2i_pkg::*;

    typedef struct packed {
        logic [63:0] bits;
        t_rmode      rmode;
    } t_conv_in;

    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic [63:0] i_value_bits = '0;
    logic [1:0]  i_mode = '0;
    logic        busy;
    logic        o_strobe;
    logic [63:0] o_result;

    t_conv_in    pending_q[$];
    logic [63:0] expected_ints[$];
    int          fail_count = 0;
    int          checked_count = 0;
    int          gap_left = 0;
    int          cycle_count = 0;
    bit          quiet_tail = 1'b0;
    bit          drain_hold = 1'b0;
    bit          drive_done = 1'b0;

    double_to_int64_rounding_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value_bits(i_value_bits),
        .i_mode      (i_mode),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    always #5 i_clk = ~i_clk;

    // Round one binary64 pattern to int64 with saturation
    function automatic logic [63:0] round_to_int64(logic [63:0] bits, t_rmode rmode);
        logic        neg;
        logic [10:0] ex;
        logic [51:0] fr;
        logic [52:0] sig;
        int          pow2;
        int          sh;
        logic [63:0] ipart;
        logic [63:0] mag;
        logic        rbit;
        logic        frac;
        neg = bits[63];
        ex  = bits[62:52];
        fr  = bits[51:0];
        if (ex == EXP_ALL_ONES) begin
            if (fr != '0) return '0;
            return neg ? INT64_MIN_BITS : INT64_MAX_BITS;
        end
        if (ex >= EXP_SATURATE) return neg ? INT64_MIN_BITS : INT64_MAX_BITS;
        sig  = (ex == '0) ? {1'b0, fr} : {1'b1, fr};
        pow2 = ((ex == '0) ? 1 : int'(ex)) - 1075;
        if (pow2 >= 0) begin
            mag = 64'(sig) << pow2;
        end else begin
            sh = -pow2;
            if (sh >= 54) begin
                ipart = '0;
                rbit  = 1'b0;
                frac  = (sig != '0);
            end else begin
                ipart = 64'(sig) >> sh;
                rbit  = sig[sh-1];
                frac  = ((64'(sig) & ((64'd1 << sh) - 64'd1)) != '0);
            end
            case (rmode)
                RM_NEAREST: mag = ipart + 64'(rbit);
                RM_FLOOR:   mag = ipart + 64'(neg && frac);
                RM_CEIL:    mag = ipart + 64'(!neg && frac);
                default:    mag = ipart;
            endcase
        end
        return neg ? (64'd0 - mag) : mag;
    endfunction

    // Random binary64 biased toward the interesting exponent band
    function automatic logic [63:0] rand_double();
        logic [10:0] ex;
        logic [51:0] fr;
        int          pick;
        pick = $urandom_range(0, 9);
        fr   = 52'({$urandom(), $urandom()});
        case (pick)
            0:       ex = 11'($urandom());
            1:       ex = 11'($urandom_range(0, 3));
            2:       ex = 11'($urandom_range(1080, 1087));
            3:       ex = EXP_ALL_ONES;
            4:       fr = fr & (52'hF << $urandom_range(0, 48));
            default: ex = 11'($urandom_range(1000, 1086));
        endcase
        if (pick == 4) ex = 11'($urandom_range(1018, 1080));
        return {1'($urandom()), ex, fr};
    endfunction

    function automatic void queue_item(logic [63:0] bits, t_rmode rmode);
        t_conv_in item;
        item.bits  = bits;
        item.rmode = rmode;
        pending_q.push_back(item);
    endfunction

    // Fill the beat queue: directed extremes, then random values
    initial begin
        logic [63:0] directed[$];
        directed = '{64'h0, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001,
                     64'h800F_FFFF_FFFF_FFFF, 64'h3FE0_0000_0000_0000,
                     64'hBFE0_0000_0000_0000, 64'h3FF8_0000_0000_0000,
                     64'hC004_0000_0000_0000, 64'h7FF0_0000_0000_0000,
                     64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_0001,
                     64'hFFFF_FFFF_FFFF_FFFF, 64'h43E0_0000_0000_0000,
                     64'hC3E0_0000_0000_0000, 64'hC3E0_0000_0000_0001,
                     64'h43DF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF,
                     64'h4330_0000_0000_0001, 64'h3FDF_FFFF_FFFF_FFFF,
                     64'hBCB0_0000_0000_0000};
        foreach (directed[k]) begin
            queue_item(directed[k], t_rmode'(k % 4));
        end
        for (int m = 0; m < 4; m++) begin
            queue_item(64'hBFF8_0000_0000_0000, t_rmode'(m));
        end
        for (int n = 0; n < 1950; n++) begin
            queue_item(rand_double(), t_rmode'($urandom_range(0, 3)));
        end
    end

    // Release reset on a falling clock edge
    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Drive beats at the falling edge, with random idle bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && busy) begin
            start <= 1'b1;
        end else if (pending_q.size() == 0) begin
            start <= 1'b0;
            drive_done <= 1'b1;
        end else if (pending_q.size() == 1000 && !drain_hold) begin
            // hold off once until every result has come back
            start <= 1'b0;
            if (expected_ints.size() == 0) drain_hold <= 1'b1;
        end else if (gap_left > 0) begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            start <= 1'b0;
            gap_left <= $urandom_range(0, 13);
        end else begin
            t_conv_in item;
            item = pending_q.pop_front();
            start <= 1'b1;
            i_value_bits <= item.bits;
            i_mode <= item.rmode;
            quiet_tail <= (pending_q.size() < 300);
        end
    end

    // Record expectations for accepted beats and check results
    always @(posedge i_clk) begin
        logic [63:0] want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && start && !busy) begin
            expected_ints.push_back(round_to_int64(i_value_bits, t_rmode'(i_mode)));
        end
        if (i_rst_n && o_strobe) begin
            if (expected_ints.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_result);
                fail_count <= fail_count + 1;
            end else begin
                want = expected_ints.pop_front();
                checked_count <= checked_count + 1;
                if (o_result !== want) begin
                    $display("%0t: result mismatch expected %h actual %h",
                             $time, want, o_result);
                    fail_count <= fail_count + 1;
                end
            end
        end
    end

    // Finish after drain, or on timeout
    initial begin
        wait (drive_done && expected_ints.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_ints.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_ints.size());
        end
        $display("Checked %0d conversions over all rounding modes, including NaN,",
                 checked_count);
        $display("infinities, saturation limits, subnormals and half-way ties.");
        if (fail_count == 0 && expected_ints.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("%0t: timeout", $time);
            $display("FAILURE");
            $finish;
        end
    end
endmodule
